// ===== hw/rtl/glob_wildcard_matcher_top_macros.svh =====
// Assertion macros shared by the glob matcher checker.
`ifndef GLOB_WILDCARD_MATCHER_TOP_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gwm_pkg.sv =====
// Shared types and constants of the glob wildcard matcher.
package gwm_pkg;

    localparam int STORE_BYTES = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LEN  = 2'd2;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    // One text word as held in the input register.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       carries_byte;
        logic       is_last;
    } item_t;

    // Stored pattern with its length already saturated.
    typedef struct packed {
        logic [STORE_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]            len;
    } pattern_t;

endpackage

// ===== hw/rtl/gwm_pattern_regs.sv =====
// Pattern configuration registers with saturation of the pattern length.
module gwm_pattern_regs
    import gwm_pkg::*;
#(
    parameter int POS_COUNT = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output pattern_t               pattern
);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_wr_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_wr_data;
                CFG_PAT_LEN:  len_reg      <= cfg_wr_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Lengths beyond the usable positions are clamped.
    always_comb
    begin
        pattern.bytes = {pat_high_reg, pat_low_reg};
        pattern.len   = (len_reg > LEN_W'(POS_COUNT)) ? LEN_W'(POS_COUNT) : len_reg;
    end

endmodule

// ===== hw/rtl/gwm_match_core.sv =====
// Active-position vector, star closure and per-byte step of the matcher.
module gwm_match_core
    import gwm_pkg::*;
#(
    parameter int POS_COUNT = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step_en,
    input  item_t    item,
    input  pattern_t pattern,
    output logic     matched
);

    localparam int POS_W  = POS_COUNT + 1;
    localparam int LEVELS = $clog2(POS_W);

    logic [POS_W-1:0] active_reg;
    logic [POS_W-1:0] active_next;
    logic [POS_W-1:0] star_moves;
    logic [POS_W-1:0] keep_mask;
    logic [POS_W-1:0] len_hot;
    logic [POS_W-1:0] cur_set;
    logic [POS_W-1:0] step_set;
    logic [POS_W-1:0] seed_after;
    logic [POS_W-1:0] final_set;

    // Closure over runs of stars as a parallel prefix: a live bit walks
    // forward across every star in front of it.
    function automatic logic [POS_W-1:0] close_set(
        input logic [POS_W-1:0] seed,
        input logic [POS_W-1:0] moves,
        input logic [POS_W-1:0] keep
    );
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] p;
        s = seed & keep;
        p = moves;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            s = s | ((s & p) << (1 << lvl));
            p = p & (p >> (1 << lvl));
        end
        return s;
    endfunction

    always_comb
    begin
        star_moves = '0;
        keep_mask  = '0;
        len_hot    = '0;
        for (int i = 0; i < POS_W; i++)
        begin
            keep_mask[i] = (LEN_W'(i) <= pattern.len);
            len_hot[i]   = (LEN_W'(i) == pattern.len);
        end
        for (int i = 0; i < POS_COUNT; i++)
        begin
            star_moves[i] = (LEN_W'(i) < pattern.len) && (pattern.bytes[i] == CHAR_STAR);
        end
    end

    always_comb
    begin
        cur_set  = close_set(active_reg, star_moves, keep_mask);
        step_set = '0;
        for (int i = 0; i < POS_COUNT; i++)
        begin
            if (cur_set[i] && (LEN_W'(i) < pattern.len))
            begin
                if (pattern.bytes[i] == CHAR_STAR)
                begin
                    step_set[i] = 1'b1;
                end
                else if ((pattern.bytes[i] == CHAR_QMARK) ||
                         (pattern.bytes[i] == item.text_byte))
                begin
                    step_set[i+1] = 1'b1;
                end
            end
        end
        seed_after = item.carries_byte ? step_set : active_reg;
        final_set  = close_set(seed_after, star_moves, keep_mask);
        matched    = |(final_set & len_hot);
    end

    always_comb
    begin
        active_next = active_reg;
        if (step_en)
        begin
            active_next = item.is_last ? POS_W'(1) : seed_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= POS_W'(1);
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== hw/rtl/glob_wildcard_matcher_top.sv =====
// Top level of the glob wildcard matcher: input register, match core, result register.
// A last word in the input register loads the result register when it moves on.
// Throughput: one text word per cycle, except while a closing word waits as below.
// Words only wait when the registered word closes a text and the previous result is held under out_stall.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the pattern
// and length to zero, and leaves only position zero active.
module glob_wildcard_matcher_top
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   carries_byte,
    input  logic                   is_last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   matched
);

    // Usable pattern positions: the parameter, bounded by the byte store.
    localparam int POS_COUNT = (MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES;

    pattern_t pattern;
    item_t    item_reg;
    logic     item_valid_reg;
    logic     item_valid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     matched_reg;
    logic     core_matched;
    logic     advance;
    logic     in_accept;

    gwm_pattern_regs #(
        .POS_COUNT (POS_COUNT)
    ) u_pattern_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .pattern     (pattern)
    );

    gwm_match_core #(
        .POS_COUNT (POS_COUNT)
    ) u_match_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .pattern (pattern),
        .matched (core_matched)
    );

    // A word that does not close a text never needs the result register, so it
    // always moves on. A closing word moves on when the result register is
    // empty or is being emptied in this cycle.
    assign advance   = item_valid_reg && (!item_reg.is_last || !out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && item_reg.is_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.text_byte    <= text_byte;
            item_reg.carries_byte <= carries_byte;
            item_reg.is_last      <= is_last;
        end
        if (advance && item_reg.is_last)
        begin
            matched_reg <= core_matched;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

// ===== hw/rtl/gwm_checker.sv =====
// Port-level checker for the glob wildcard matcher, bound to the top level.
`include "glob_wildcard_matcher_top_macros.svh"

module gwm_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic is_last,
    input logic out_valid,
    input logic out_stall,
    input logic matched
);

    // A stalled result holds its value.
    `GWM_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(matched), "stalled result word changed or vanished")

    // The input side only waits behind a result that is itself blocked.
    `GWM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

    // A closing word taken while no result is held must go on to show a result.
    `GWM_ASSERT_NOW(a_result_latency, in_valid && !in_stall && is_last && !out_valid, ##2 out_valid, "no result two cycles after a closing word")

endmodule

bind glob_wildcard_matcher_top gwm_checker u_checker (.*);
